// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and held off
// while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the next cycle: cond |=> prop.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

// Implication checked in the same cycle: cond |-> prop.
`define ASSERT_SAME(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ----- rtl/core/rme_pkg.sv -----
// ---------------------------------------------------------------------------
// rme_pkg
// Widths and register codes of the modular exponentiation unit.
// ---------------------------------------------------------------------------
package rme_pkg;

    // Width of the modulus, the exponents and every operand.
    localparam int MOD_W = 40;

    // Bit counter of the shift-add-reduce multiplier.
    localparam int CNT_W = $clog2(MOD_W);

    // Configuration register index width and codes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd2;

    typedef logic [MOD_W-1:0] t_word;

endpackage

// ----- rtl/core/rsa_modular_exponentiation_unit.sv -----
// ---------------------------------------------------------------------------
// rsa_modular_exponentiation_unit
// Raises each input value to the public or private exponent modulo the
// modulus by right-to-left square-and-multiply on one shared
// shift-add-reduce multiplier.
// ---------------------------------------------------------------------------
//  Channel   | Direction | Content
//  ----------+-----------+-----------------------------------------------
//  s_axis    | in        | tdata: base_value; tuser: mode; tlast: end flag
//  m_axis    | out       | tdata: power_result; tlast: end flag
//  cfg       | in        | index 0 public, 1 private exponent, 2 modulus
//
//  Each modular product doubles the accumulator once per bit of its second
//  operand, adding the first after the doubling for each set bit; one
//  modular add per cycle in the shared multiplier. An item runs a base
//  reduction, then per exponent bit a check, for a set bit a multiply,
//  and a square; the square after the top set bit is skipped. A zero
//  exponent goes from the base reduction through one check to done.
//  The input is ready only while the sequencer is idle; a finished result
//  waits in the output register, so a new item can enter meanwhile.
//  Reset is synchronous, active low, and sets the exponents to 0 and the
//  modulus to 1. The configuration port is always ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rsa_modular_exponentiation_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input item stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [rme_pkg::MOD_W-1:0]      i_s_axis_tdata,   // [39:0] base_value
    input  logic                           i_s_axis_tuser,   // [0] mode
    input  logic                           i_s_axis_tlast,
    // Result item stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [rme_pkg::MOD_W-1:0]      o_m_axis_tdata,   // [39:0] power_result
    output logic                           o_m_axis_tlast,
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rme_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rme_pkg::MOD_W-1:0]      i_cfg_data
);

    localparam int MW = rme_pkg::MOD_W;
    localparam int CW = rme_pkg::CNT_W;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MULT  = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Where a finished product goes.
    localparam logic [1:0] DST_POWER  = 2'd0;
    localparam logic [1:0] DST_RESULT = 2'd1;
    localparam logic [1:0] DST_SQUARE = 2'd2;

    logic [1:0]          r_state, n_state;
    rme_pkg::t_word      r_pub, n_pub;
    rme_pkg::t_word      r_priv, n_priv;
    rme_pkg::t_word      r_mod, n_mod;
    rme_pkg::t_word      r_expo, n_expo;
    rme_pkg::t_word      r_power, n_power;
    rme_pkg::t_word      r_result, n_result;
    rme_pkg::t_word      r_a, n_a;
    rme_pkg::t_word      r_b, n_b;
    rme_pkg::t_word      r_acc, n_acc;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_phase, n_phase;
    logic [1:0]          r_dst, n_dst;
    logic                r_last, n_last;
    logic                r_out_valid, n_out_valid;
    rme_pkg::t_word      r_out_data, n_out_data;
    logic                r_out_last, n_out_last;

    logic                s_accept;
    logic                cfg_write;
    logic                out_free;
    rme_pkg::t_word      add_y;
    logic [MW:0]         add_sum;
    logic [MW+1:0]       add_diff;
    rme_pkg::t_word      add_red;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_write       = i_cfg_valid && o_cfg_ready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // Shared modular adder: doubles the accumulator or adds the multiplicand,
    // then subtracts the modulus once if the sum reached it. A zero modulus
    // stands for 2^MOD_W, so the sum simply wraps.
    always_comb begin
        add_y    = r_phase ? r_a : r_acc;
        add_sum  = {1'b0, r_acc} + {1'b0, add_y};
        add_diff = {1'b0, add_sum} - {2'b00, r_mod};
        if ((r_mod != '0) && !add_diff[MW+1]) begin
            add_red = add_diff[MW-1:0];
        end else begin
            add_red = add_sum[MW-1:0];
        end
    end

    // Sequencer and next-state logic.
    always_comb begin
        n_state     = r_state;
        n_pub       = r_pub;
        n_priv      = r_priv;
        n_mod       = r_mod;
        n_expo      = r_expo;
        n_power     = r_power;
        n_result    = r_result;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_phase     = r_phase;
        n_dst       = r_dst;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        // Configuration writes; an unknown index is ignored.
        if (cfg_write) begin
            unique case (i_cfg_index)
                rme_pkg::CFG_PUB_EXP:  n_pub  = i_cfg_data;
                rme_pkg::CFG_PRIV_EXP: n_priv = i_cfg_data;
                rme_pkg::CFG_MODULUS:  n_mod  = i_cfg_data;
                default: ;
            endcase
        end

        // The output register empties when the result item is taken.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                // Reduce the base first: 1 * base through the multiplier.
                if (s_accept) begin
                    n_expo   = i_s_axis_tuser ? r_priv : r_pub;
                    n_last   = i_s_axis_tlast;
                    n_result = MW'(1);
                    n_a      = MW'(1);
                    n_b      = i_s_axis_tdata;
                    n_acc    = '0;
                    n_cnt    = CW'(MW - 1);
                    n_phase  = 1'b0;
                    n_dst    = DST_POWER;
                    n_state  = ST_MULT;
                end
            end
            ST_MULT: begin
                n_acc = add_red;
                if (!r_phase && r_b[MW-1]) begin
                    // Bit set: the add step follows the doubling.
                    n_phase = 1'b1;
                end else begin
                    n_phase = 1'b0;
                    n_b     = r_b << 1;
                    n_cnt   = r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        case (r_dst)
                            DST_POWER: begin
                                n_power = add_red;
                                n_state = ST_CHECK;
                            end
                            DST_RESULT: begin
                                n_result = add_red;
                                if (r_expo[MW-1:1] == '0) begin
                                    // No exponent bits left: skip the square.
                                    n_expo  = '0;
                                    n_state = ST_CHECK;
                                end else begin
                                    n_a     = r_power;
                                    n_b     = r_power;
                                    n_acc   = '0;
                                    n_cnt   = CW'(MW - 1);
                                    n_dst   = DST_SQUARE;
                                end
                            end
                            default: begin
                                n_power = add_red;
                                n_expo  = r_expo >> 1;
                                n_state = ST_CHECK;
                            end
                        endcase
                    end
                end
            end
            ST_CHECK: begin
                // Next exponent bit: multiply when set, else square only.
                n_acc   = '0;
                n_cnt   = CW'(MW - 1);
                n_phase = 1'b0;
                if (r_expo == '0) begin
                    n_state = ST_DONE;
                end else if (r_expo[0]) begin
                    n_a     = r_result;
                    n_b     = r_power;
                    n_dst   = DST_RESULT;
                    n_state = ST_MULT;
                end else begin
                    n_a     = r_power;
                    n_b     = r_power;
                    n_dst   = DST_SQUARE;
                    n_state = ST_MULT;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_result;
                    n_out_last  = r_last;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_pub       <= '0;
            r_priv      <= '0;
            r_mod       <= MW'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pub       <= n_pub;
            r_priv      <= n_priv;
            r_mod       <= n_mod;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_expo     <= n_expo;
        r_power    <= n_power;
        r_result   <= n_result;
        r_a        <= n_a;
        r_b        <= n_b;
        r_acc      <= n_acc;
        r_cnt      <= n_cnt;
        r_phase    <= n_phase;
        r_dst      <= n_dst;
        r_last     <= n_last;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // An accepted item always starts the base reduction.
    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, s_accept, (r_state == ST_MULT) && (r_dst == DST_POWER), "accepted item did not start the multiplier")

    // A finished result waits while the output register is still full.
    `ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, (r_state == ST_DONE) && !out_free, r_state == ST_DONE, "sequencer left the done state with a full output register")

    // A finished result is loaded and the sequencer returns to idle.
    `ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, (r_state == ST_DONE) && out_free, r_out_valid && (r_state == ST_IDLE), "finished result was not loaded into the output register")

endmodule
